FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms that use the clk and arst_n of the module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/kels_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event level sequencer package
// Step type, operation and action codes, and the level rewrite of modifiers.
// ----------------------------------------------------------------------------
package kels_pkg;

	typedef struct packed {
		logic [7:0] key;
		logic [7:0] mods;
		logic       down;
	} step_t;

	localparam logic [3:0] OP_TICK      = 4'd0;
	localparam logic [3:0] OP_PLAIN     = 4'd1;
	localparam logic [3:0] OP_SHIFT     = 4'd2;
	localparam logic [3:0] OP_ALTGR     = 4'd3;
	localparam logic [3:0] OP_ALT       = 4'd4;
	localparam logic [3:0] OP_SHIFT_ALT = 4'd5;
	localparam logic [3:0] OP_LEVEL3    = 4'd6;
	localparam logic [3:0] OP_LEVEL4    = 4'd7;
	localparam logic [3:0] OP_PASS      = 4'd8;
	localparam logic [3:0] OP_MODIFIER  = 4'd9;
	localparam logic [3:0] OP_VIRTUAL   = 4'd10;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_MODS    = 2'd1;
	localparam logic [1:0] ACT_PRESS   = 2'd2;
	localparam logic [1:0] ACT_RELEASE = 2'd3;

	localparam logic [7:0] MOD_SHIFT  = 8'h02;
	localparam logic [7:0] MOD_RSHIFT = 8'h20;
	localparam logic [7:0] MOD_RALT   = 8'h40;

	localparam logic [7:0] HID_NONE   = 8'd0;
	localparam logic [7:0] HID_CAPS   = 8'd57;
	localparam logic [7:0] HID_BSLASH = 8'd49;
	localparam logic [7:0] HID_ISOX   = 8'd100;

	localparam logic [2:0] VM_CAPS   = 3'b001;
	localparam logic [2:0] VM_BSLASH = 3'b010;
	localparam logic [2:0] VM_ISOX   = 3'b100;
	localparam logic [2:0] VM_LEVEL3 = 3'b011;
	localparam logic [2:0] VM_LEVEL4 = 3'b100;

	function automatic logic [7:0] level_mods(input logic [7:0] m, input logic [3:0] lvl);
		logic [7:0] v;
		v = m;
		case (lvl)
			OP_PLAIN: begin
				v = m & ~(MOD_SHIFT | MOD_RSHIFT | MOD_RALT);
			end
			OP_SHIFT: begin
				v = m & ~MOD_RALT;
				if ((v & (MOD_SHIFT | MOD_RSHIFT)) == 8'h00) begin
					v = v | MOD_SHIFT;
				end
			end
			OP_ALTGR, OP_ALT: begin
				v = (m & ~(MOD_SHIFT | MOD_RSHIFT)) | MOD_RALT;
			end
			OP_SHIFT_ALT: begin
				v = m | MOD_SHIFT | MOD_RALT;
			end
			default: begin
				v = m;
			end
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/key_event_level_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event level sequencer
// Rewrites key events for their target level, queues the resulting key steps
// and on each tick item sends the queue head's modifiers or key to the host.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_stall with op, key and press. Every item
// gives exactly one result on out_valid/out_stall.
// A key event with at most one step is taken in S_IDLE, and its result
// sits in the output register in the cycle after acceptance. A level-3 or
// level-4 event that queues two steps writes its second step to the step
// memory in S_PUSH2.
// A tick reads the queue head from the step memory, whose read data is
// registered, so a tick passes through S_TICK and its result is loaded into
// the output register at the end of S_TICK.
// A new item is taken only in S_IDLE and while the output register is empty
// or its result leaves in the same cycle; while the receiver stalls and the
// output register is full, in_stall stays high.
// Reset empties the queue and clears the held, virtual and sent modifiers.
// The step memory needs no clearing pass, since only written entries are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_event_level_sequencer_top #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] op,
	input  logic [7:0] key,
	input  logic       press,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] action,
	output logic [7:0] key_out,
	output logic [7:0] modifiers_out,
	output logic [1:0] dropped
);
	import kels_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_TICK  = 3'b010,
		S_PUSH2 = 3'b100
	} state_t;

	state_t        state_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] cnt_q;
	logic [7:0]    held_q;
	logic [2:0]    vm_q;
	logic [7:0]    sent_q;
	step_t         pend_q;

	logic       out_valid_q;
	logic [1:0] action_q;
	logic [7:0] key_out_q;
	logic [7:0] mods_out_q;
	logic [1:0] dropped_q;

	logic          accept;
	logic [7:0]    virt_key;
	logic [2:0]    flag;
	logic [2:0]    group;
	logic          v_push;
	logic [2:0]    vm_virt;
	step_t         v_step;
	step_t         lvl_step;
	step_t         a_step;
	step_t         b_step;
	logic          a_vld;
	logic          b_vld;
	logic [7:0]    held_n;
	logic [2:0]    vm_n;
	logic          a_wr;
	logic          b_wr;
	logic          a_drop;
	logic          b_drop;
	logic [AW-1:0] cnt1;
	logic [1:0]    drop_sum;

	step_t         rd_step;
	logic          mem_we;
	step_t         mem_wdata;
	logic [AW-1:0] tail_nxt;
	logic [AW-1:0] head_nxt;

	logic          t_pop;
	logic [1:0]    t_action;
	logic [7:0]    t_key;
	logic [7:0]    t_sent;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign tail_nxt  = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign head_nxt  = (head_q == LAST) ? '0 : head_q + 1'b1;

	always_comb begin
		virt_key = key;
		if (op == OP_LEVEL3) begin
			virt_key = HID_CAPS;
		end else if (op == OP_LEVEL4) begin
			virt_key = HID_ISOX;
		end
		flag  = 3'b000;
		group = 3'b000;
		if (virt_key == HID_CAPS) begin
			flag  = VM_CAPS;
			group = VM_LEVEL3;
		end else if (virt_key == HID_BSLASH) begin
			flag  = VM_BSLASH;
			group = VM_LEVEL3;
		end else if (virt_key == HID_ISOX) begin
			flag  = VM_ISOX;
			group = VM_LEVEL4;
		end
		v_push  = press ? ((vm_q & group) == 3'b000) : ((vm_q & flag) != 3'b000);
		vm_virt = vm_q;
		if (v_push) begin
			vm_virt = press ? (vm_q | flag) : (vm_q & ~flag);
		end
		v_step   = '{key: virt_key, mods: held_q, down: press};
		lvl_step = '{key: key, mods: level_mods(held_q, OP_PLAIN), down: press};
	end

	always_comb begin
		a_vld  = 1'b0;
		b_vld  = 1'b0;
		a_step = lvl_step;
		b_step = lvl_step;
		held_n = held_q;
		vm_n   = vm_q;
		case (op)
			OP_PLAIN, OP_SHIFT, OP_ALTGR, OP_ALT, OP_SHIFT_ALT: begin
				a_vld  = 1'b1;
				a_step = '{key: key, mods: level_mods(held_q, op), down: press};
			end
			OP_LEVEL3, OP_LEVEL4: begin
				vm_n  = vm_virt;
				a_vld = 1'b1;
				if (press) begin
					if (v_push) begin
						a_step = v_step;
						b_step = lvl_step;
						b_vld  = 1'b1;
					end
				end else begin
					b_step = v_step;
					b_vld  = v_push;
				end
			end
			OP_PASS: begin
				a_vld  = 1'b1;
				a_step = '{key: key, mods: held_q, down: press};
			end
			OP_MODIFIER: begin
				held_n = press ? (held_q | key) : (held_q & ~key);
				a_vld  = 1'b1;
				a_step = '{key: HID_NONE, mods: held_n, down: press};
			end
			OP_VIRTUAL: begin
				vm_n   = vm_virt;
				a_vld  = v_push;
				a_step = v_step;
			end
			default: begin
				a_vld = 1'b0;
			end
		endcase
		a_drop   = a_vld && (cnt_q == LAST);
		a_wr     = a_vld && (cnt_q != LAST);
		cnt1     = cnt_q + {{(AW-1){1'b0}}, a_wr};
		b_drop   = b_vld && (cnt1 == LAST);
		b_wr     = b_vld && (cnt1 != LAST);
		drop_sum = {1'b0, a_drop} + {1'b0, b_drop};
	end

	always_comb begin
		t_pop    = 1'b0;
		t_action = ACT_NONE;
		t_key    = HID_NONE;
		t_sent   = sent_q;
		if (cnt_q != '0) begin
			if (rd_step.key == HID_NONE) begin
				t_sent   = rd_step.mods;
				t_action = ACT_MODS;
				t_pop    = 1'b1;
			end else if (sent_q != rd_step.mods) begin
				t_sent   = rd_step.mods;
				t_action = ACT_MODS;
			end else begin
				t_action = rd_step.down ? ACT_PRESS : ACT_RELEASE;
				t_key    = rd_step.key;
				t_pop    = 1'b1;
			end
		end
	end

	assign mem_we    = (accept && (op != OP_TICK) && a_wr) || (state_q == S_PUSH2);
	assign mem_wdata = (state_q == S_PUSH2) ? pend_q : a_step;

	kels_step_ram #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata (mem_wdata),
		.raddr (head_q),
		.rdata (rd_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			held_q  <= '0;
			vm_q    <= '0;
			sent_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_TICK) begin
							state_q <= S_TICK;
						end else begin
							held_q <= held_n;
							vm_q   <= vm_n;
							if (a_wr) begin
								tail_q <= tail_nxt;
								cnt_q  <= cnt1;
							end
							if (b_wr) begin
								state_q <= S_PUSH2;
							end
						end
					end
				end
				S_TICK: begin
					sent_q  <= t_sent;
					state_q <= S_IDLE;
					if (t_pop) begin
						head_q <= head_nxt;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				S_PUSH2: begin
					tail_q  <= tail_nxt;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op != OP_TICK) && b_wr) begin
			pend_q <= b_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && (op != OP_TICK)) || (state_q == S_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op != OP_TICK)) begin
			action_q   <= ACT_NONE;
			key_out_q  <= HID_NONE;
			mods_out_q <= sent_q;
			dropped_q  <= drop_sum;
		end else if (state_q == S_TICK) begin
			action_q   <= t_action;
			key_out_q  <= t_key;
			mods_out_q <= t_sent;
			dropped_q  <= 2'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign key_out       = key_out_q;
	assign modifiers_out = mods_out_q;
	assign dropped       = dropped_q;

	`ASSERT_SAME(a_empty_ptrs, cnt_q == '0, head_q == tail_q)
	`ASSERT_SAME(a_ptrs_empty, head_q == tail_q, cnt_q == '0)
	`ASSERT_SAME(a_no_overrun, in_valid && !in_stall, !out_valid_q || !out_stall)
	`ASSERT_NEXT(a_tick_done, state_q == S_TICK, state_q == S_IDLE && out_valid_q)

endmodule

FILE: rtl/kels_step_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step queue memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kels_step_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  kels_pkg::step_t      wdata,
	input  logic [AW-1:0]        raddr,
	output kels_pkg::step_t      rdata
);
	import kels_pkg::*;

	step_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
